// ===== hdl/hrm_pkg.sv =====
// ----------------------------------------------------------------------------
// hrm_pkg
// Shared types and constants of the heightfield ray marcher.
// ----------------------------------------------------------------------------
package hrm_pkg;

   localparam int GRID_MAX_DEF = 256;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Z    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT = 3'd6;

   localparam logic [30:0] SCALE_RST = 31'd65536;
   localparam logic [8:0]  WIDTH_RST = 9'd256;
   localparam logic [15:0] LIMIT_RST = 16'd5000;

   localparam logic OPC_WRITE = 1'b0;
   localparam logic OPC_RAY   = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [15:0]        cell_index;
      logic signed [31:0] height_value;
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic signed [31:0] cam_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } item_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic [30:0]        scale_x;
      logic [30:0]        scale_z;
      logic [8:0]         grid_width;
      logic [15:0]        step_limit;
   } cfg_type;

endpackage

// ===== hdl/hrm_ram.sv =====
// ----------------------------------------------------------------------------
// hrm_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hrm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/hrm_div.sv =====
// ----------------------------------------------------------------------------
// hrm_div
// Restoring divider, one quotient bit per cycle, for quotients known to fit
// in QW bits (the starting remainder is below the divisor).
// ----------------------------------------------------------------------------
module hrm_div #(
   parameter int DW = 32,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] rem_init,
   input  logic [QW-1:0] low,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   localparam int CW = $clog2(QW + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] div_ff, div_in;
   logic [QW-1:0] low_ff, low_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   cat;
   logic [DW:0]   diff;
   logic          ge;

   always_comb begin
      cat  = {rem_ff, low_ff[QW-1]};
      ge   = cat >= {1'b0, div_ff};
      diff = cat - {1'b0, div_ff};
      rem_in  = rem_ff;
      div_in  = div_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = rem_init;
         div_in  = divisor;
         low_in  = low;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : cat[DW-1:0];
         quo_in = QW'({quo_ff, ge});
         low_in = low_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/hrm_front.sv =====
// ----------------------------------------------------------------------------
// hrm_front
// Input side: takes items off the request channel into a two-entry queue.
// ----------------------------------------------------------------------------
module hrm_front import hrm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  item_type req_item,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type    slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;

   assign req_stall = (count_ff == 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// ===== hdl/hrm_back.sv =====
// ----------------------------------------------------------------------------
// hrm_back
// Execution side: height writes, direction normalisation and the step loop.
// ----------------------------------------------------------------------------
module hrm_back import hrm_pkg::*; #(
   parameter int GRID_MAX = GRID_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   input  cfg_type            cfg,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [7:0]         rsp_hit_row,
   output logic [7:0]         rsp_hit_col,
   output logic [15:0]        rsp_steps_used,
   output logic signed [31:0] rsp_last_x,
   output logic signed [31:0] rsp_last_z
);

   localparam int QB    = $clog2(GRID_MAX);
   localparam int WW    = $clog2(GRID_MAX + 1);
   localparam int CELLS = GRID_MAX * GRID_MAX;
   localparam int AW    = $clog2(CELLS);
   localparam int SWW   = 31 + WW;
   localparam int NW    = SWW + 2;
   localparam int GDW   = 33;
   localparam int UQW   = 17;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SQ    = 4'd1;
   localparam logic [3:0] ST_SQRT  = 4'd2;
   localparam logic [3:0] ST_UNIT  = 4'd3;
   localparam logic [3:0] ST_UWAIT = 4'd4;
   localparam logic [3:0] ST_PREP  = 4'd5;
   localparam logic [3:0] ST_TOP   = 4'd6;
   localparam logic [3:0] ST_RANGE = 4'd7;
   localparam logic [3:0] ST_GDIV  = 4'd8;
   localparam logic [3:0] ST_ADDR  = 4'd9;
   localparam logic [3:0] ST_RD    = 4'd10;
   localparam logic [3:0] ST_CMP   = 4'd11;
   localparam logic [3:0] ST_ADV   = 4'd12;
   localparam logic [3:0] ST_OUT   = 4'd13;

   function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                  logic signed [17:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      if (s > 33'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (s < -33'sd2147483648) begin
         return 32'sh80000000;
      end
      return s[31:0];
   endfunction

   logic [3:0]            state_ff, state_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic signed [31:0]    px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [31:0]    dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [63:0]           prod_ff, prod_in;
   logic [63:0]           sum_ff, sum_in;
   logic [63:0]           root_ff, root_in;
   logic [63:0]           bit_ff, bit_in;
   logic signed [17:0]    ux_ff, ux_in, uy_ff, uy_in, uz_ff, uz_in;
   logic [WW-1:0]         w_ff, w_in;
   logic [SWW-1:0]        swx_ff, swx_in, swz_ff, swz_in;
   logic [15:0]           steps_ff, steps_in;
   logic signed [NW-1:0]  numx_ff, numx_in, numz_ff, numz_in;
   logic                  negx_ff, negx_in, negz_ff, negz_in;
   logic [QB-1:0]         row_ff, row_in, col_ff, col_in;
   logic [AW-1:0]         cell_ff, cell_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [7:0]            rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [15:0]           rsp_steps_ff, rsp_steps_in;
   logic signed [31:0]    rsp_x_ff, rsp_x_in, rsp_z_ff, rsp_z_in;
   logic                  hit_ff, hit_in;

   logic signed [31:0]    sel;
   logic [31:0]           mag;
   logic [63:0]           trial;
   logic [30:0]           sxe, sze;
   logic signed [NW-1:0]  limx, limz, negx_lim, negz_lim;
   logic                  inx, inz;
   logic signed [17:0]    uval;
   logic signed [32:0]    ref_h;

   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr;
   logic [31:0]           ram_rdata;

   logic                  udiv_start, udiv_done;
   logic [UQW-1:0]        udiv_q;
   logic                  gdiv_start, gx_done, gz_done;
   logic [QB-1:0]         gx_q, gz_q;
   logic [GDW-1:0]        gx_rem, gz_rem;
   logic [QB-1:0]         gx_low, gz_low;

   hrm_ram #(.WIDTH(32), .DEPTH(CELLS)) u_heights (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (q_item.height_value),
      .rd_en   (ram_re),
      .rd_addr (cell_ff),
      .rd_data (ram_rdata)
   );

   hrm_div #(.DW(32), .QW(UQW)) u_unit_div (
      .clock    (clock),
      .reset    (reset),
      .start    (udiv_start),
      .rem_init ({1'b0, mag[31:1]}),
      .low      ({mag[0], 16'd0}),
      .divisor  (root_ff[31:0]),
      .done     (udiv_done),
      .quotient (udiv_q)
   );

   hrm_div #(.DW(GDW), .QW(QB)) u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (gdiv_start),
      .rem_init (gx_rem),
      .low      (gx_low),
      .divisor  ({1'b0, sxe, 1'b0}),
      .done     (gx_done),
      .quotient (gx_q)
   );

   hrm_div #(.DW(GDW), .QW(QB)) u_row_div (
      .clock    (clock),
      .reset    (reset),
      .start    (gdiv_start),
      .rem_init (gz_rem),
      .low      (gz_low),
      .divisor  ({1'b0, sze, 1'b0}),
      .done     (gz_done),
      .quotient (gz_q)
   );

   always_comb begin
      if (cnt_ff == 5'd0) begin
         sel = dx_ff;
      end else if (cnt_ff == 5'd1) begin
         sel = dy_ff;
      end else begin
         sel = dz_ff;
      end
      mag      = sel[31] ? 32'(-sel) : 32'(sel);
      trial    = root_ff + bit_ff;
      sxe      = (cfg.scale_x == 31'd0) ? 31'd1 : cfg.scale_x;
      sze      = (cfg.scale_z == 31'd0) ? 31'd1 : cfg.scale_z;
      limx     = signed'(NW'({swx_ff, 1'b0}));
      limz     = signed'(NW'({swz_ff, 1'b0}));
      negx_lim = -signed'(NW'({sxe, 1'b0}));
      negz_lim = -signed'(NW'({sze, 1'b0}));
      inx = (!numx_ff[NW-1] && numx_ff < limx) ||
            (numx_ff[NW-1] && numx_ff > negx_lim && w_ff != '0);
      inz = (!numz_ff[NW-1] && numz_ff < limz) ||
            (numz_ff[NW-1] && numz_ff > negz_lim && w_ff != '0);
      gx_rem = numx_ff[NW-1] ? '0 : numx_ff[QB+GDW-1:QB];
      gz_rem = numz_ff[NW-1] ? '0 : numz_ff[QB+GDW-1:QB];
      gx_low = numx_ff[NW-1] ? '0 : numx_ff[QB-1:0];
      gz_low = numz_ff[NW-1] ? '0 : numz_ff[QB-1:0];
      uval   = sel[31] ? -signed'({1'b0, udiv_q}) : signed'({1'b0, udiv_q});
      ref_h  = 33'(signed'(ram_rdata)) + 33'(cfg.origin_y);
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      pz_in     = pz_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      dz_in     = dz_ff;
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      ux_in     = ux_ff;
      uy_in     = uy_ff;
      uz_in     = uz_ff;
      w_in      = w_ff;
      swx_in    = swx_ff;
      swz_in    = swz_ff;
      steps_in  = steps_ff;
      numx_in   = numx_ff;
      numz_in   = numz_ff;
      negx_in   = negx_ff;
      negz_in   = negz_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      cell_in   = cell_ff;
      hit_in    = hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_steps_in = rsp_steps_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_z_in     = rsp_z_ff;
      q_pop      = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_waddr  = AW'(q_item.cell_index);
      udiv_start = 1'b0;
      gdiv_start = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.opcode == OPC_WRITE) begin
                  ram_we = (32'(q_item.cell_index) < 32'(CELLS));
               end else begin
                  px_in  = q_item.cam_x;
                  py_in  = q_item.cam_y;
                  pz_in  = q_item.cam_z;
                  dx_in  = q_item.dir_x;
                  dy_in  = q_item.dir_y;
                  dz_in  = q_item.dir_z;
                  cnt_in = '0;
                  sum_in = '0;
                  w_in   = (32'(cfg.grid_width) > 32'(GRID_MAX)) ? WW'(GRID_MAX)
                                                                  : WW'(cfg.grid_width);
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            prod_in = 64'(mag) * 64'(mag);
            sum_in  = sum_ff + ((cnt_ff != 5'd0) ? prod_ff : 64'd0);
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               root_in  = '0;
               bit_in   = 64'h4000_0000_0000_0000;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sum_ff >= trial) begin
               sum_in  = sum_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               cnt_in   = '0;
               state_in = ST_UNIT;
            end
         end
         ST_UNIT: begin
            if (root_ff[31:0] == 32'd0) begin
               ux_in    = '0;
               uy_in    = '0;
               uz_in    = '0;
               state_in = ST_PREP;
            end else begin
               udiv_start = 1'b1;
               state_in   = ST_UWAIT;
            end
         end
         ST_UWAIT: begin
            if (udiv_done) begin
               if (cnt_ff == 5'd0) begin
                  ux_in = uval;
               end else if (cnt_ff == 5'd1) begin
                  uy_in = uval;
               end else begin
                  uz_in = uval;
               end
               cnt_in   = cnt_ff + 5'd1;
               state_in = (cnt_ff == 5'd2) ? ST_PREP : ST_UNIT;
            end
         end
         ST_PREP: begin
            swx_in   = SWW'(sxe) * SWW'(w_ff);
            swz_in   = SWW'(sze) * SWW'(w_ff);
            steps_in = '0;
            state_in = ST_TOP;
         end
         ST_TOP: begin
            if (steps_ff >= cfg.step_limit) begin
               hit_in   = 1'b0;
               state_in = ST_OUT;
            end else begin
               numx_in  = ((NW'(px_ff) - NW'(cfg.origin_x)) <<< 1) + NW'(swx_ff);
               numz_in  = ((NW'(pz_ff) - NW'(cfg.origin_z)) <<< 1) + NW'(swz_ff);
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            negx_in = numx_ff[NW-1];
            negz_in = numz_ff[NW-1];
            if (inx && inz) begin
               gdiv_start = 1'b1;
               state_in   = ST_GDIV;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_GDIV: begin
            if (gx_done && gz_done) begin
               col_in   = negx_ff ? '0 : gx_q;
               row_in   = negz_ff ? '0 : gz_q;
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            cell_in  = AW'(32'(col_ff) * 32'(w_ff) + 32'(row_ff));
            state_in = ST_RD;
         end
         ST_RD: begin
            ram_re   = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (33'(py_ff) <= ref_h) begin
               hit_in   = 1'b1;
               state_in = ST_OUT;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            px_in    = sat_add(px_ff, ux_ff);
            py_in    = sat_add(py_ff, uy_ff);
            pz_in    = sat_add(pz_ff, uz_ff);
            steps_in = steps_ff + 16'd1;
            state_in = ST_TOP;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_row_in   = hit_ff ? 8'(row_ff) : 8'd0;
               rsp_col_in   = hit_ff ? 8'(col_ff) : 8'd0;
               rsp_steps_in = steps_ff;
               rsp_x_in     = px_ff;
               rsp_z_in     = pz_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff   <= cnt_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      pz_ff    <= pz_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dz_ff    <= dz_in;
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      ux_ff    <= ux_in;
      uy_ff    <= uy_in;
      uz_ff    <= uz_in;
      w_ff     <= w_in;
      swx_ff   <= swx_in;
      swz_ff   <= swz_in;
      steps_ff <= steps_in;
      numx_ff  <= numx_in;
      numz_ff  <= numz_in;
      negx_ff  <= negx_in;
      negz_ff  <= negz_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      cell_ff  <= cell_in;
      hit_ff   <= hit_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_steps_ff <= rsp_steps_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_z_ff     <= rsp_z_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_hit_row    = rsp_row_ff;
   assign rsp_hit_col    = rsp_col_ff;
   assign rsp_steps_used = rsp_steps_ff;
   assign rsp_last_x     = rsp_x_ff;
   assign rsp_last_z     = rsp_z_ff;

endmodule

// ===== hdl/heightfield_ray_march.sv =====
// ----------------------------------------------------------------------------
// heightfield_ray_march
// Fixed-step ray marcher over a square height grid held in block RAM.
// ----------------------------------------------------------------------------
// height write items: written by the execution unit from its idle state
// ray items: normalisation (squares, square root, three divides), then per step
// the position ranging, the grid-coordinate dividers, the registered height read
// and the compare inside the grid, ranging alone outside it, and on a miss the advance
// reset is synchronous: control and registers return to defaults, heights kept
// ----------------------------------------------------------------------------
module heightfield_ray_march import hrm_pkg::*; #(
   parameter int GRID_MAX = GRID_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [15:0]           req_cell_index,
   input  logic signed [31:0]    req_height_value,
   input  logic signed [31:0]    req_cam_x,
   input  logic signed [31:0]    req_cam_y,
   input  logic signed [31:0]    req_cam_z,
   input  logic signed [31:0]    req_dir_x,
   input  logic signed [31:0]    req_dir_y,
   input  logic signed [31:0]    req_dir_z,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_hit,
   output logic [7:0]            rsp_hit_row,
   output logic [7:0]            rsp_hit_col,
   output logic [15:0]           rsp_steps_used,
   output logic signed [31:0]    rsp_last_x,
   output logic signed [31:0]    rsp_last_z,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   item_type req_item;
   item_type q_item;
   logic     q_valid;
   logic     q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ORIGIN_X:   cfg_in.origin_x   = csr_wdata;
            CSR_ORIGIN_Y:   cfg_in.origin_y   = csr_wdata;
            CSR_ORIGIN_Z:   cfg_in.origin_z   = csr_wdata;
            CSR_SCALE_X:    cfg_in.scale_x    = csr_wdata[30:0];
            CSR_SCALE_Z:    cfg_in.scale_z    = csr_wdata[30:0];
            CSR_GRID_WIDTH: cfg_in.grid_width = csr_wdata[8:0];
            CSR_STEP_LIMIT: cfg_in.step_limit = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
         cfg_ff.origin_z   <= '0;
         cfg_ff.scale_x    <= SCALE_RST;
         cfg_ff.scale_z    <= SCALE_RST;
         cfg_ff.grid_width <= WIDTH_RST;
         cfg_ff.step_limit <= LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item.opcode       = req_opcode;
   assign req_item.cell_index   = req_cell_index;
   assign req_item.height_value = req_height_value;
   assign req_item.cam_x        = req_cam_x;
   assign req_item.cam_y        = req_cam_y;
   assign req_item.cam_z        = req_cam_z;
   assign req_item.dir_x        = req_dir_x;
   assign req_item.dir_y        = req_dir_y;
   assign req_item.dir_z        = req_dir_z;

   hrm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   hrm_back #(.GRID_MAX(GRID_MAX)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .cfg            (cfg_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_hit_row    (rsp_hit_row),
      .rsp_hit_col    (rsp_hit_col),
      .rsp_steps_used (rsp_steps_used),
      .rsp_last_x     (rsp_last_x),
      .rsp_last_z     (rsp_last_z)
   );

   a_stall_needs_items: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_valid)
      else $error("request stalled with an empty queue");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_miss_zero_cell: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_hit_row == 8'd0 && rsp_hit_col == 8'd0))
      else $error("miss carries a nonzero cell");

   a_pop_only_valid: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_valid) |=> 1'b0)
      else $error("queue popped while empty");

endmodule

// ===== test/heightfield_ray_march_check.sv =====
// ----------------------------------------------------------------------------
// heightfield_ray_march_check
// Watches the request, response and register ports of the ray marcher, keeps
// its own copy of the height grid and settings, predicts each ray outcome and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module heightfield_ray_march_check import hrm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [15:0]           req_cell_index,
   input  logic signed [31:0]    req_height_value,
   input  logic signed [31:0]    req_cam_x,
   input  logic signed [31:0]    req_cam_y,
   input  logic signed [31:0]    req_cam_z,
   input  logic signed [31:0]    req_dir_x,
   input  logic signed [31:0]    req_dir_y,
   input  logic signed [31:0]    req_dir_z,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_hit,
   input  logic [7:0]            rsp_hit_row,
   input  logic [7:0]            rsp_hit_col,
   input  logic [15:0]           rsp_steps_used,
   input  logic signed [31:0]    rsp_last_x,
   input  logic signed [31:0]    rsp_last_z,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    failures,
   output int                    pending,
   output int                    rays_seen,
   output int                    hits_seen
);

   typedef struct {
      logic               hit;
      logic [7:0]         row;
      logic [7:0]         col;
      logic [15:0]        steps;
      logic signed [31:0] last_x;
      logic signed [31:0] last_z;
   } ray_outcome_type;

   localparam int CELLS = GRID_MAX_DEF * GRID_MAX_DEF;

   logic signed [31:0] heights [0:CELLS-1];
   cfg_type            cfg;
   ray_outcome_type    outcomes [$];

   assign pending = outcomes.size();

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unit_part(longint d, logic [63:0] len);
      logic [63:0] mag;
      longint      q;
      if (len == 0) return 0;
      mag = (d < 0) ? -d : d;
      q = longint'((mag << 16) / len);
      return (d < 0) ? -q : q;
   endfunction

   function automatic longint cell_coord(longint p, longint org, longint scale, longint width);
      longint s;
      longint num;
      s = (scale == 0) ? 1 : scale;
      num = 2 * (p - org) + s * width;
      return num / (2 * s);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic ray_outcome_type march_ray(longint px, longint py, longint pz,
                                                 longint dx, longint dy, longint dz);
      ray_outcome_type res;
      logic [63:0]     len;
      longint          ux, uy, uz, width, row, col, steps;
      logic            hit;
      len = int_sqrt(64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz));
      ux = unit_part(dx, len);
      uy = unit_part(dy, len);
      uz = unit_part(dz, len);
      width = (cfg.grid_width > GRID_MAX_DEF) ? GRID_MAX_DEF : cfg.grid_width;
      steps = 0;
      hit = 1'b0;
      row = 0;
      col = 0;
      while (steps < cfg.step_limit) begin
         row = cell_coord(pz, cfg.origin_z, cfg.scale_z, width);
         col = cell_coord(px, cfg.origin_x, cfg.scale_x, width);
         if (row >= 0 && row < width && col >= 0 && col < width) begin
            if (py <= longint'(heights[col * width + row]) + longint'(cfg.origin_y)) begin
               hit = 1'b1;
               break;
            end
         end
         px = clamp32(px + ux);
         py = clamp32(py + uy);
         pz = clamp32(pz + uz);
         steps++;
      end
      if (!hit) begin
         row = 0;
         col = 0;
      end
      res.hit = hit;
      res.row = row[7:0];
      res.col = col[7:0];
      res.steps = steps[15:0];
      res.last_x = px[31:0];
      res.last_z = pz[31:0];
      return res;
   endfunction

   always @(posedge clock) begin
      ray_outcome_type exp_o;
      if (reset) begin
         cfg.origin_x   <= '0;
         cfg.origin_y   <= '0;
         cfg.origin_z   <= '0;
         cfg.scale_x    <= SCALE_RST;
         cfg.scale_z    <= SCALE_RST;
         cfg.grid_width <= WIDTH_RST;
         cfg.step_limit <= LIMIT_RST;
         outcomes.delete();
         failures  <= 0;
         rays_seen <= 0;
         hits_seen <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ORIGIN_X:   cfg.origin_x   <= csr_wdata;
               CSR_ORIGIN_Y:   cfg.origin_y   <= csr_wdata;
               CSR_ORIGIN_Z:   cfg.origin_z   <= csr_wdata;
               CSR_SCALE_X:    cfg.scale_x    <= csr_wdata[30:0];
               CSR_SCALE_Z:    cfg.scale_z    <= csr_wdata[30:0];
               CSR_GRID_WIDTH: cfg.grid_width <= csr_wdata[8:0];
               CSR_STEP_LIMIT: cfg.step_limit <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_opcode == OPC_WRITE) begin
               if (req_cell_index < CELLS) heights[req_cell_index] = req_height_value;
            end else begin
               outcomes.push_back(march_ray(req_cam_x, req_cam_y, req_cam_z,
                                            req_dir_x, req_dir_y, req_dir_z));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (outcomes.size() == 0) begin
               $error("result with no ray outstanding");
               failures <= failures + 1;
            end else begin
               exp_o = outcomes.pop_front();
               rays_seen <= rays_seen + 1;
               if (rsp_hit) hits_seen <= hits_seen + 1;
               if (rsp_hit !== exp_o.hit ||
                   rsp_hit_row !== exp_o.row ||
                   rsp_hit_col !== exp_o.col ||
                   rsp_steps_used !== exp_o.steps ||
                   rsp_last_x !== exp_o.last_x ||
                   rsp_last_z !== exp_o.last_z) begin
                  if (rsp_hit !== exp_o.hit)
                     $error("hit: expected %0d, got %0d", exp_o.hit, rsp_hit);
                  if (rsp_hit_row !== exp_o.row)
                     $error("hit_row: expected %0d, got %0d", exp_o.row, rsp_hit_row);
                  if (rsp_hit_col !== exp_o.col)
                     $error("hit_col: expected %0d, got %0d", exp_o.col, rsp_hit_col);
                  if (rsp_steps_used !== exp_o.steps)
                     $error("steps_used: expected %0d, got %0d", exp_o.steps, rsp_steps_used);
                  if (rsp_last_x !== exp_o.last_x)
                     $error("last_x: expected %0d, got %0d", exp_o.last_x, rsp_last_x);
                  if (rsp_last_z !== exp_o.last_z)
                     $error("last_z: expected %0d, got %0d", exp_o.last_z, rsp_last_z);
                  failures <= failures + 1;
               end
            end
         end
      end
   end

endmodule

// ===== test/heightfield_ray_march_test.sv =====
// ----------------------------------------------------------------------------
// heightfield_ray_march_test
// Loads every cell of a grid up to four wide, casts directed rays at the edge
// settings, then random rays and height writes across several settings and
// idling patterns, including a long response hold-off. A checker module does
// the prediction.
// ----------------------------------------------------------------------------
module heightfield_ray_march_test;
   import hrm_pkg::*;

   localparam int QUIET_LIMIT = 400000;
   localparam longint ONE = 65536;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_stall;
   logic                  req_opcode = 0;
   logic [15:0]           req_cell_index = 0;
   logic signed [31:0]    req_height_value = 0;
   logic signed [31:0]    req_cam_x = 0;
   logic signed [31:0]    req_cam_y = 0;
   logic signed [31:0]    req_cam_z = 0;
   logic signed [31:0]    req_dir_x = 0;
   logic signed [31:0]    req_dir_y = 0;
   logic signed [31:0]    req_dir_z = 0;
   logic                  rsp_valid;
   logic                  rsp_stall = 0;
   logic                  rsp_hit;
   logic [7:0]            rsp_hit_row;
   logic [7:0]            rsp_hit_col;
   logic [15:0]           rsp_steps_used;
   logic signed [31:0]    rsp_last_x;
   logic signed [31:0]    rsp_last_z;
   logic                  csr_write = 0;
   logic [CSR_IDX_W-1:0]  csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_wdata = 0;

   int failures, pending, rays_seen, hits_seen;
   int tx_pct = 0;
   int rx_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int quiet = 0;
   int writes_sent = 0;
   int settings_used = 0;

   longint cur_ox, cur_oy, cur_oz, cur_sx, cur_sz, cur_w;

   heightfield_ray_march dut (.*);

   heightfield_ray_march_check checker_i (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // response side stall, with one long hold-off
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_item(item_type it);
      while ($urandom_range(99) < tx_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_opcode       <= it.opcode;
      req_cell_index   <= it.cell_index;
      req_height_value <= it.height_value;
      req_cam_x        <= it.cam_x;
      req_cam_y        <= it.cam_y;
      req_cam_z        <= it.cam_z;
      req_dir_x        <= it.dir_x;
      req_dir_y        <= it.dir_y;
      req_dir_z        <= it.dir_z;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (it.opcode == OPC_WRITE) writes_sent++;
      @(negedge clock);
   endtask

   function automatic item_type height_write(longint idx, longint value);
      item_type it;
      it.opcode = OPC_WRITE;
      it.cell_index = idx[15:0];
      it.height_value = value[31:0];
      it.cam_x = $urandom;
      it.cam_y = $urandom;
      it.cam_z = $urandom;
      it.dir_x = $urandom;
      it.dir_y = $urandom;
      it.dir_z = $urandom;
      return it;
   endfunction

   function automatic item_type ray(longint cx, longint cy, longint cz,
                                    longint dx, longint dy, longint dz);
      item_type it;
      it.opcode = OPC_RAY;
      it.cell_index = $urandom;
      it.height_value = $urandom;
      it.cam_x = cx[31:0];
      it.cam_y = cy[31:0];
      it.cam_z = cz[31:0];
      it.dir_x = dx[31:0];
      it.dir_y = dy[31:0];
      it.dir_z = dz[31:0];
      return it;
   endfunction

   function automatic longint small_height();
      return longint'($urandom_range(0, 16 * ONE)) - 8 * ONE;
   endfunction

   function automatic item_type random_ray();
      longint span_x, span_z;
      if ($urandom_range(7) == 0)
         return ray($signed($urandom), $signed($urandom), $signed($urandom),
                    $signed($urandom), $signed($urandom), $signed($urandom));
      span_x = cur_w * cur_sx / 2 + 3 * ONE;
      span_z = cur_w * cur_sz / 2 + 3 * ONE;
      return ray(cur_ox + longint'($urandom_range(0, 2 * span_x)) - span_x,
                 cur_oy + longint'($urandom_range(0, 24 * ONE)) - 12 * ONE,
                 cur_oz + longint'($urandom_range(0, 2 * span_z)) - span_z,
                 longint'($urandom_range(0, 2 * ONE)) - ONE,
                 longint'($urandom_range(0, ONE + ONE / 4)) - ONE,
                 longint'($urandom_range(0, 2 * ONE)) - ONE);
   endfunction

   function automatic item_type random_write();
      if ($urandom_range(7) == 0) return height_write($urandom, $signed($urandom));
      return height_write($urandom_range(0, cur_w * cur_w - 1), small_height());
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // wait for the block to drain, then load all registers
   task automatic set_regs(longint ox, longint oy, longint oz, longint sx, longint sz,
                           longint w, longint lim);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (150) @(negedge clock);
      write_reg(CSR_ORIGIN_X, ox[31:0]);
      write_reg(CSR_ORIGIN_Y, oy[31:0]);
      write_reg(CSR_ORIGIN_Z, oz[31:0]);
      write_reg(CSR_SCALE_X, sx[31:0]);
      write_reg(CSR_SCALE_Z, sz[31:0]);
      write_reg(CSR_GRID_WIDTH, w[31:0]);
      write_reg(CSR_STEP_LIMIT, lim[31:0]);
      csr_write <= 1'b0;
      cur_ox = ox;
      cur_oy = oy;
      cur_oz = oz;
      cur_sx = (sx == 0) ? 1 : sx;
      cur_sz = (sz == 0) ? 1 : sz;
      cur_w = (w > GRID_MAX_DEF) ? GRID_MAX_DEF : ((w == 0) ? 1 : w);
      settings_used++;
   endtask

   initial begin
      cur_ox = 0; cur_oy = 0; cur_oz = 0;
      cur_sx = ONE; cur_sz = ONE; cur_w = GRID_MAX_DEF;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every cell of a grid up to four wide, so no ray reads an unloaded height
      for (int i = 0; i < 16; i++)
         send_item(height_write(i, (i % 4 == 0) ? longint'($signed($urandom)) :
                                                  small_height()));
      send_item(height_write(0, 32'sh7fff_ffff));
      send_item(height_write(1, -64'sd2147483648));
      send_item(height_write(16'hffff, small_height()));

      tx_pct = 9;
      rx_pct = 46;
      // reset settings: only rays that stay off the grid or sit on the first two cells
      send_item(ray(1000 * ONE, 0, 0, 0, 0, 0));
      send_item(ray(32'sh7fff_ffff, 32'sh7fff_ffff, -64'sd2147483648, ONE, ONE, -ONE));
      send_item(ray(-127 * ONE - ONE / 2, 0, -127 * ONE - ONE / 2, 0, -ONE, 0));
      send_item(ray(-127 * ONE - ONE / 2, 0, -126 * ONE - ONE / 2, 0, -ONE, 0));

      // four-wide grid spanning -2..2 units
      set_regs(0, 0, 0, ONE, ONE, 4, 5000);
      send_item(ray(0, 100 * ONE, 0, 0, -ONE, 0));
      send_item(ray(0, 0, 0, 32'sh7fff_ffff, -64'sd2147483648, -64'sd2147483648));
      send_item(ray(5 * ONE, -64'sd2147483648, 7 * ONE, ONE, 0, 0));
      send_item(ray(-130 * ONE, 20 * ONE, ONE, ONE, -ONE / 8, 0));

      set_regs(0, 0, 0, ONE, ONE, 1, 0);
      send_item(ray(0, -ONE, 0, 0, -ONE, 0));
      set_regs(0, ONE, 0, ONE, ONE, 1, 20);
      send_item(ray(0, 20 * ONE, 0, ONE / 8, -ONE, 0));
      send_item(ray(-ONE / 4, 20 * ONE, ONE / 4, 0, -ONE, ONE / 16));
      set_regs(0, 0, 0, 0, 0, 0, 10);
      send_item(ray(0, -64'sd2147483648, 0, 0, 0, 0));
      set_regs(0, 0, 0, 0, 0, 4, 10);
      send_item(ray(1, -64'sd2147483648, -1, 0, 0, 0));
      send_item(ray(-3, 100 * ONE, 2, 0, -ONE, 0));
      // wide grid and extreme origins: only rays that land at once
      set_regs(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
               1 << 25, 1 << 25, 511, 65535);
      send_item(ray(-64'sd2147483648, 32'sh7fff_ffff, -64'sd2147483648, ONE, ONE, ONE));
      set_regs(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, ONE, ONE, 2, 1);
      send_item(ray(-64'sd2147483648, 0, -64'sd2147483648, -ONE, 0, -ONE));
      send_item(ray(-64'sd2147483648, 32'sh7fff_ffff, -64'sd2147483648, ONE, -ONE, 0));

      for (int mode = 0; mode < 3; mode++) begin
         tx_pct = (mode == 0) ? 9 : ((mode == 1) ? 46 : 0);
         rx_pct = (mode == 0) ? 46 : ((mode == 1) ? 9 : 0);
         for (int k = 0; k < 2; k++) begin
            set_regs(longint'($urandom_range(0, 1 << 21)) - (1 << 20),
                     longint'($urandom_range(0, 1 << 21)) - (1 << 20),
                     longint'($urandom_range(0, 1 << 21)) - (1 << 20),
                     $urandom_range(ONE / 2, 2 * ONE), $urandom_range(ONE / 2, 2 * ONE),
                     $urandom_range(1, 4),
                     $urandom_range(1, 200));
            if (mode == 2 && k == 0) begin
               hold_request = 8000;
               repeat (8) send_item(random_write());
               repeat (4) send_item(random_ray());
            end
            for (int n = 0; n < 12; n++) begin
               if ($urandom_range(9) < 7) send_item(random_ray());
               else send_item(random_write());
            end
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("covered %0d rays (%0d hits) and %0d height writes", rays_seen, hits_seen,
               writes_sent);
      $display("over %0d register settings and three idling patterns", settings_used);
      if (failures == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/hrm_pkg.sv
hdl/hrm_ram.sv
hdl/hrm_div.sv
hdl/hrm_front.sv
hdl/hrm_back.sv
hdl/heightfield_ray_march.sv
test/heightfield_ray_march_check.sv
test/heightfield_ray_march_test.sv
